FILE: rtl/fhcp_pkg.sv
`default_nettype none

package fhcp_pkg;

  // Header framing and check constants.
  localparam logic [7:0]  BeginCode  = 8'hB8;
  localparam logic [15:0] YuvCode    = 16'h01A6;
  localparam logic [6:0]  CheckScale = 7'd100;

  // Fixed dividend offset: begin code squared.
  localparam logic [16:0] DividendBase = 17'(int'(BeginCode) * int'(BeginCode));

  // Header byte positions after the begin code.
  localparam logic [3:0] PhaseHunt = 4'd0;
  localparam logic [3:0] PhaseLast = 4'd10;

  // Datapath sizes of the divider.
  localparam int unsigned QuoWidth = 17;
  localparam int unsigned DivWidth = 18;
  localparam int unsigned CntWidth = $clog2(QuoWidth);

  // Result status codes.
  localparam logic [1:0] StatusMatch    = 2'd0;
  localparam logic [1:0] StatusMismatch = 2'd1;
  localparam logic [1:0] StatusZeroDiv  = 2'd2;

  // Packed widths of the stream payloads.
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 72;

endpackage

`default_nettype wire

FILE: rtl/frame_header_check_parser.sv
`default_nettype none

// Channel   Direction  Payload
// -------   ---------  ------------------------------------------------------------
// s_axis    in         tdata[7:0] data_byte; tuser datagram_start
// m_axis    out        tdata status, is_yuv, frame_width, frame_height,
//                      frame_number, received_check (low bit up), zero padded
//
// Header bytes are taken one per cycle while the parser is idle. The last header byte
// starts a restoring divider that retires one quotient bit per cycle, and then a scale
// and compare step follows, so a completed header keeps the input stalled until both end.
// A zero divisor skips the divider and its result is ready in the next cycle.
// Reset is asynchronous and active low; it returns the parser to the hunt.
// Bytes keep flowing while a result waits; only a last header byte is held until it goes.
module frame_header_check_parser (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // Fields from bit 0: data_byte[7:0].
  input  wire  [fhcp_pkg::InDataWidth-1:0]         s_axis_tdata_i,
  // Fields from bit 0: datagram_start.
  input  wire                                      s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire                                      m_axis_tready_i,
  // Fields from bit 0: status[1:0], is_yuv[2], frame_width[18:3],
  // frame_height[34:19], frame_number[50:35], received_check[66:51], zeros.
  output logic [fhcp_pkg::OutDataWidth-1:0]        m_axis_tdata_o
);

  import fhcp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL
  } state_e;

  state_e                 state_q;
  logic [3:0]             phase_q;
  logic [15:0]            enc_q;
  logic [15:0]            width_q;
  logic [15:0]            height_q;
  logic [15:0]            id_q;
  logic [7:0]             check_hi_q;
  logic [15:0]            check_q;

  // Divider registers: quotient shifts in while the dividend shifts out.
  logic [DivWidth-1:0]    div_q;
  logic                   neg_q;
  logic [DivWidth-1:0]    rem_q;
  logic [QuoWidth-1:0]    quo_q;
  logic [CntWidth-1:0]    cnt_q;

  // Result register.
  logic                   out_valid_q;
  logic [1:0]             out_status_q;
  logic                   out_yuv_q;
  logic [15:0]            out_width_q;
  logic [15:0]            out_height_q;
  logic [15:0]            out_id_q;
  logic [15:0]            out_check_q;

  logic                   in_fire;
  logic [3:0]             phase_eff;
  logic [7:0]             in_byte;
  logic [DivWidth-1:0]    triple_w;
  logic [DivWidth:0]      divisor_s;
  logic [DivWidth-1:0]    divisor_mag;
  logic [DivWidth:0]      shifted;
  logic                   ge;
  logic [DivWidth:0]      trial;
  logic [23:0]            prod;
  logic [15:0]            scaled;

  // A last header byte would need the result register, so hold it back while
  // a previous result is still waiting to be taken.
  assign s_axis_tready_o = (state_q == ST_IDLE) && !((phase_q == PhaseLast) && out_valid_q);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_byte         = s_axis_tdata_i;

  // Datagram start, or a phase outside the header, restarts the hunt.
  assign phase_eff = (s_axis_tuser_i || (phase_q > PhaseLast)) ? PhaseHunt : phase_q;

  // Divisor 3*width - height as a signed value, then its magnitude.
  always_comb begin
    triple_w    = {1'b0, width_q, 1'b0} + {2'b00, width_q};
    divisor_s   = {1'b0, triple_w} - {3'b000, height_q};
    divisor_mag = divisor_s[DivWidth] ? DivWidth'(-divisor_s) : divisor_s[DivWidth-1:0];
  end

  // One restoring step of the subtract and compare unit.
  always_comb begin
    shifted = {rem_q, quo_q[QuoWidth-1]};
    trial   = shifted - {1'b0, div_q};
    ge      = shifted >= {1'b0, div_q};
  end

  // Scale the quotient; only the low 16 bits matter, so the sign is applied there.
  always_comb begin
    prod   = {7'd0, quo_q} * {17'd0, CheckScale};
    scaled = neg_q ? 16'(-prod[15:0]) : prod[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PhaseHunt;
      enc_q        <= '0;
      width_q      <= '0;
      height_q     <= '0;
      id_q         <= '0;
      check_hi_q   <= '0;
      check_q      <= '0;
      div_q        <= '0;
      neg_q        <= 1'b0;
      rem_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StatusMatch;
      out_yuv_q    <= 1'b0;
      out_width_q  <= '0;
      out_height_q <= '0;
      out_id_q     <= '0;
      out_check_q  <= '0;
    end else begin
      // A new result is only loaded while the register is empty.
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if ((phase_eff != PhaseHunt) && (phase_eff < PhaseLast)) begin
              phase_q <= phase_eff + 4'd1;
            end
            unique case (phase_eff)
              4'd0: begin
                phase_q <= (in_byte == BeginCode) ? 4'd1 : PhaseHunt;
              end
              4'd1: enc_q      <= {in_byte, 8'h00};
              4'd2: enc_q      <= {enc_q[15:8], in_byte};
              4'd3: width_q    <= {in_byte, 8'h00};
              4'd4: width_q    <= {width_q[15:8], in_byte};
              4'd5: height_q   <= {in_byte, 8'h00};
              4'd6: height_q   <= {height_q[15:8], in_byte};
              4'd7: id_q       <= {in_byte, 8'h00};
              4'd8: id_q       <= {id_q[15:8], in_byte};
              4'd9: check_hi_q <= in_byte;
              default: begin
                // Last header byte: the words are complete, start the check.
                phase_q <= PhaseHunt;
                check_q <= {check_hi_q, in_byte};
                if (divisor_mag == '0) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= StatusZeroDiv;
                  out_yuv_q    <= (enc_q == YuvCode);
                  out_width_q  <= width_q;
                  out_height_q <= height_q;
                  out_id_q     <= id_q;
                  out_check_q  <= {check_hi_q, in_byte};
                end else begin
                  div_q   <= divisor_mag;
                  neg_q   <= divisor_s[DivWidth];
                  rem_q   <= '0;
                  quo_q   <= DividendBase + {1'b0, enc_q};
                  cnt_q   <= CntWidth'(QuoWidth - 1);
                  state_q <= ST_DIV;
                end
              end
            endcase
          end
        end
        ST_DIV: begin
          rem_q <= ge ? trial[DivWidth-1:0] : shifted[DivWidth-1:0];
          quo_q <= {quo_q[QuoWidth-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          out_valid_q  <= 1'b1;
          out_status_q <= (scaled == check_q) ? StatusMatch : StatusMismatch;
          out_yuv_q    <= (enc_q == YuvCode);
          out_width_q  <= width_q;
          out_height_q <= height_q;
          out_id_q     <= id_q;
          out_check_q  <= check_q;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_check_q, out_id_q, out_height_q, out_width_q,
                            out_yuv_q, out_status_q};

endmodule

`default_nettype wire
